>>> rtl/core/zph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zph_pkg: shared types and constants for the Zobrist hash block
// Command record, sequencer states and table geometry.
// ----------------------------------------------------------------------------
package zph_pkg;

  localparam int unsigned KeyW       = 64;
  localparam int unsigned IdxW       = 10;
  localparam int unsigned SqW        = 6;
  localparam int unsigned Squares    = 64;
  localparam int unsigned PieceTypes = 6;
  localparam int unsigned PieceKinds = 12;
  localparam int unsigned ExtraBase  = 768;
  localparam int unsigned TableDepth = 774;
  localparam int unsigned ExtraKeys  = 6;
  localparam int unsigned ExtraSelW  = 3;
  localparam int unsigned TypeW      = 3;
  localparam int unsigned FlagW      = 6;
  localparam int unsigned BankDepth  = 128;
  localparam int unsigned BankAddrW  = 7;
  localparam int unsigned QueueDepth = 2;

  // floor(idx / 12) == (idx * 2731) >> 15 for every idx below 768
  localparam logic [11:0] RecipTwelve = 12'd2731;
  localparam int unsigned RecipShift  = 15;

  localparam logic OpLoad = 1'b0;
  localparam logic OpHash = 1'b1;

  // position flag bits; extra keys follow the same order
  localparam int unsigned FlagBlackToMove = 0;
  localparam int unsigned FlagEpValid     = 1;

  typedef enum logic [1:0] {
    CMD_LOAD_BANK,
    CMD_LOAD_EXTRA,
    CMD_HASH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                           kind;
    logic [TypeW-1:0]                    piece_type;
    logic [BankAddrW-1:0]                bank_addr;
    logic [ExtraSelW-1:0]                extra_sel;
    logic [KeyW-1:0]                     key;
    logic [PieceTypes-1:0][KeyW-1:0]     boards;
    logic [KeyW-1:0]                     white;
    logic [FlagW-1:0]                    flags;
    logic [SqW-1:0]                      ep;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH,
    ST_FINISH
  } back_state_t;

endpackage

>>> rtl/core/zph_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zph_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module zph_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/zph_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zph_front: input decode
// Classify each transaction and split a key index into bank and address.
// ----------------------------------------------------------------------------
module zph_front (
  input  logic                        push,
  input  logic                        op,
  input  logic [zph_pkg::IdxW-1:0]    key_index,
  input  logic [zph_pkg::KeyW-1:0]    key_value,
  input  logic [zph_pkg::KeyW-1:0]    king_board,
  input  logic [zph_pkg::KeyW-1:0]    queen_board,
  input  logic [zph_pkg::KeyW-1:0]    rook_board,
  input  logic [zph_pkg::KeyW-1:0]    bishop_board,
  input  logic [zph_pkg::KeyW-1:0]    knight_board,
  input  logic [zph_pkg::KeyW-1:0]    pawn_board,
  input  logic [zph_pkg::KeyW-1:0]    white_board,
  input  logic [zph_pkg::FlagW-1:0]   position_flags,
  input  logic [zph_pkg::SqW-1:0]     ep_square,
  input  logic                        q_full,
  output logic                        enq,
  output zph_pkg::cmd_t               enq_cmd
);

  logic [21:0]              prod;
  logic [zph_pkg::SqW-1:0]  square;
  logic [zph_pkg::IdxW-1:0] sq_x12;
  logic [zph_pkg::IdxW-1:0] rem;
  logic [zph_pkg::IdxW-1:0] extra_off;
  logic                     drop;

  always_comb begin
    // square = key_index / 12 by reciprocal multiply
    prod   = {12'd0, key_index} * {10'd0, zph_pkg::RecipTwelve};
    square = prod[zph_pkg::RecipShift +: zph_pkg::SqW];
    sq_x12 = {1'b0, square, 3'b000} + {2'b00, square, 2'b00};
    rem    = key_index - sq_x12;
    extra_off = key_index - zph_pkg::IdxW'(zph_pkg::ExtraBase);

    drop = 1'b0;
    enq_cmd.kind       = zph_pkg::CMD_HASH;
    enq_cmd.piece_type = rem[zph_pkg::TypeW:1];
    enq_cmd.bank_addr  = {square, rem[0]};
    enq_cmd.extra_sel  = extra_off[zph_pkg::ExtraSelW-1:0];
    enq_cmd.key        = key_value;
    enq_cmd.boards     = {pawn_board, knight_board, bishop_board,
                          rook_board, queen_board, king_board};
    enq_cmd.white      = white_board;
    enq_cmd.flags      = position_flags;
    enq_cmd.ep         = ep_square;

    if (op == zph_pkg::OpLoad) begin
      if (key_index < zph_pkg::IdxW'(zph_pkg::ExtraBase)) begin
        enq_cmd.kind = zph_pkg::CMD_LOAD_BANK;
      end else if (key_index < zph_pkg::IdxW'(zph_pkg::TableDepth)) begin
        enq_cmd.kind = zph_pkg::CMD_LOAD_EXTRA;
      end else begin
        drop = 1'b1;  // out-of-range load: accept and discard
      end
    end

    enq = push && !q_full && !drop;
  end

endmodule

>>> rtl/core/zph_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zph_queue: command queue
// Short FIFO between decode and the hashing sequencer.
// ----------------------------------------------------------------------------
module zph_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  zph_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd_en,
  output zph_pkg::head_t head
);

  localparam int unsigned PtrW = $clog2(zph_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(zph_pkg::QueueDepth + 1);

  zph_pkg::cmd_t   slots [zph_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full       = (count == CntW'(zph_pkg::QueueDepth));
  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrW'(zph_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrW'(zph_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(wr_en) - CntW'(rd_en);
    end
  end

endmodule

>>> rtl/core/zph_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zph_back: key table and hashing sequencer
// Write loaded keys; walk 64 squares per hash and hold the result.
// ----------------------------------------------------------------------------
module zph_back (
  input  logic                      clk,
  input  logic                      rst,
  input  zph_pkg::head_t            head,
  output logic                      deq,
  output logic                      empty,
  input  logic                      pop,
  output logic [zph_pkg::KeyW-1:0]  hash_value
);

  zph_pkg::back_state_t state, state_next;

  logic [zph_pkg::SqW-1:0]   cnt;
  logic [zph_pkg::SqW-1:0]   rd_sq;
  logic                      rd_valid;
  logic [zph_pkg::KeyW-1:0]  acc;
  logic                      res_valid;
  logic [zph_pkg::KeyW-1:0]  res;
  logic [zph_pkg::KeyW-1:0]  extra_key [zph_pkg::ExtraKeys];

  logic                      issue;
  logic                      start;
  logic                      load_res;
  logic                      extra_we;
  logic [zph_pkg::PieceTypes-1:0] bank_we;
  logic [zph_pkg::BankAddrW-1:0]  raddr;
  logic [zph_pkg::KeyW-1:0]  rdata [zph_pkg::PieceTypes];
  logic [zph_pkg::KeyW-1:0]  sq_keys;
  logic [zph_pkg::KeyW-1:0]  final_hash;

  // black piece sits at odd address: color = 1 when the white bit is clear
  assign raddr = {cnt, ~head.cmd.white[cnt]};

  for (genvar t = 0; t < zph_pkg::PieceTypes; t++) begin : g_bank
    zph_ram #(
      .DEPTH (zph_pkg::BankDepth),
      .WIDTH (zph_pkg::KeyW)
    ) u_bank (
      .clk   (clk),
      .we    (bank_we[t]),
      .waddr (head.cmd.bank_addr),
      .wdata (head.cmd.key),
      .raddr (raddr),
      .rdata (rdata[t])
    );
  end

  always_comb begin
    sq_keys = '0;
    for (int t = 0; t < zph_pkg::PieceTypes; t++) begin
      if (head.cmd.boards[t][rd_sq]) begin
        sq_keys = sq_keys ^ rdata[t];
      end
    end
  end

  always_comb begin
    final_hash = acc;
    for (int f = 0; f < zph_pkg::ExtraKeys; f++) begin
      if (head.cmd.flags[f]) begin
        final_hash = final_hash ^ extra_key[f];
      end
    end
    if (head.cmd.flags[zph_pkg::FlagEpValid]) begin
      final_hash = final_hash ^ {{(zph_pkg::KeyW - 3){1'b0}},
                                 head.cmd.ep[2:0] ^ head.cmd.ep[5:3]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zph_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    deq        = 1'b0;
    issue      = 1'b0;
    start      = 1'b0;
    load_res   = 1'b0;
    extra_we   = 1'b0;
    bank_we    = '0;
    unique case (state)
      zph_pkg::ST_IDLE: begin
        if (head.valid) begin
          unique case (head.cmd.kind)
            zph_pkg::CMD_LOAD_BANK: begin
              bank_we[head.cmd.piece_type] = 1'b1;
              deq = 1'b1;
            end
            zph_pkg::CMD_LOAD_EXTRA: begin
              extra_we = 1'b1;
              deq      = 1'b1;
            end
            zph_pkg::CMD_HASH: begin
              start      = 1'b1;
              state_next = zph_pkg::ST_WALK;
            end
            default: deq = 1'b1;
          endcase
        end
      end
      zph_pkg::ST_WALK: begin
        issue = 1'b1;
        if (cnt == zph_pkg::SqW'(zph_pkg::Squares - 1)) begin
          state_next = zph_pkg::ST_FLUSH;
        end
      end
      zph_pkg::ST_FLUSH: begin
        state_next = zph_pkg::ST_FINISH;
      end
      zph_pkg::ST_FINISH: begin
        // hold until the result slot is free
        if (!res_valid || pop) begin
          load_res   = 1'b1;
          deq        = 1'b1;
          state_next = zph_pkg::ST_IDLE;
        end
      end
      default: state_next = zph_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rd_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (issue) begin
        cnt <= cnt + 1'b1;
      end
      if (load_res) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_sq <= cnt;
    end
    if (start) begin
      acc <= '0;
    end else if (rd_valid) begin
      acc <= acc ^ sq_keys;
    end
    if (load_res) begin
      res <= final_hash;
    end
    if (extra_we) begin
      extra_key[head.cmd.extra_sel] <= head.cmd.key;
    end
  end

  assign empty      = !res_valid;
  assign hash_value = res;

endmodule

>>> rtl/core/chess_position_zobrist_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chess_position_zobrist_hash: Zobrist hash of a chess position
// Loads 774 64-bit keys and hashes positions given as piece bitboards.
// ----------------------------------------------------------------------------
//
//   channel  | handshake        | payload
//   ---------+------------------+--------------------------------------------
//   input    | push / full      | op, key_index, key_value, six piece boards,
//            |                  | white_board, position_flags, ep_square
//   result   | empty / pop      | hash_value (one per hash transaction)
//
// A load transaction is written and dequeued by the idle sequencer; a hash
// transaction starts, reads the 64 squares, drains the last read and folds in
// side, en passant and castle keys, waiting to finish while the result slot is
// full. The walk visits one square per cycle, reading each of the six key
// banks (one per piece type) once per square.
// Reset clears control only; the key table holds no valid state until loaded
// and needs no clearing pass. A two-entry queue accepts transactions until full
// while a hash runs or a finished result waits to be popped.
// ----------------------------------------------------------------------------
module chess_position_zobrist_hash (
  input  logic                        clk,
  input  logic                        rst,
  // input queue side
  input  logic                        push,
  output logic                        full,
  input  logic                        op,
  input  logic [zph_pkg::IdxW-1:0]    key_index,
  input  logic [zph_pkg::KeyW-1:0]    key_value,
  input  logic [zph_pkg::KeyW-1:0]    king_board,
  input  logic [zph_pkg::KeyW-1:0]    queen_board,
  input  logic [zph_pkg::KeyW-1:0]    rook_board,
  input  logic [zph_pkg::KeyW-1:0]    bishop_board,
  input  logic [zph_pkg::KeyW-1:0]    knight_board,
  input  logic [zph_pkg::KeyW-1:0]    pawn_board,
  input  logic [zph_pkg::KeyW-1:0]    white_board,
  input  logic [zph_pkg::FlagW-1:0]   position_flags,
  input  logic [zph_pkg::SqW-1:0]     ep_square,
  // result queue side
  output logic                        empty,
  input  logic                        pop,
  output logic [zph_pkg::KeyW-1:0]    hash_value
);

  logic           enq;
  zph_pkg::cmd_t  enq_cmd;
  logic           deq;
  zph_pkg::head_t head;

  // Decode: drop out-of-range loads, split the key index into bank and slot.
  zph_front u_front (
    .push           (push),
    .op             (op),
    .key_index      (key_index),
    .key_value      (key_value),
    .king_board     (king_board),
    .queen_board    (queen_board),
    .rook_board     (rook_board),
    .bishop_board   (bishop_board),
    .knight_board   (knight_board),
    .pawn_board     (pawn_board),
    .white_board    (white_board),
    .position_flags (position_flags),
    .ep_square      (ep_square),
    .q_full         (full),
    .enq            (enq),
    .enq_cmd        (enq_cmd)
  );

  // Hold decoded commands so decode and hashing stall independently.
  zph_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (enq),
    .wr_cmd (enq_cmd),
    .full   (full),
    .rd_en  (deq),
    .head   (head)
  );

  // Execute: write keys, walk the board, register the result.
  zph_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .deq        (deq),
    .empty      (empty),
    .pop        (pop),
    .hash_value (hash_value)
  );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the Zobrist position hash block
// Fills the key table, runs directed positions and flag corners, then a long
// random mix of key reloads, dropped loads and positions. Both queue sides
// idle at random. Each hash is predicted from a private copy of the key table.
// ----------------------------------------------------------------------------
typedef struct packed {
  logic                                              op;
  logic [zph_pkg::IdxW-1:0]                          key_index;
  logic [zph_pkg::KeyW-1:0]                          key_value;
  logic [zph_pkg::PieceTypes-1:0][zph_pkg::KeyW-1:0] boards;
  logic [zph_pkg::KeyW-1:0]                          white;
  logic [zph_pkg::FlagW-1:0]                         flags;
  logic [zph_pkg::SqW-1:0]                           ep;
} txn_t;

class hash_scoreboard;
  logic [zph_pkg::KeyW-1:0] key_table [zph_pkg::TableDepth];
  logic [zph_pkg::KeyW-1:0] hashes_due [$];
  int unsigned              loads, dropped_loads, hashes, checked, errors;

  function logic [zph_pkg::KeyW-1:0] position_hash(txn_t t);
    logic [zph_pkg::KeyW-1:0] h;
    int                       ty, sq, k;
    h = '0;
    for (ty = 0; ty < zph_pkg::PieceTypes; ty++) begin
      for (sq = 0; sq < zph_pkg::Squares; sq++) begin
        if (t.boards[ty][sq]) begin
          h ^= key_table[sq * zph_pkg::PieceKinds + 2 * ty + (t.white[sq] ? 0 : 1)];
        end
      end
    end
    for (k = 0; k < zph_pkg::ExtraKeys; k++) begin
      if (t.flags[k]) begin
        h ^= key_table[zph_pkg::ExtraBase + k];
      end
    end
    if (t.flags[zph_pkg::FlagEpValid]) begin
      h ^= zph_pkg::KeyW'(t.ep[2:0] ^ t.ep[5:3]);
    end
    return h;
  endfunction

  function void note_input(txn_t t);
    if (t.op == zph_pkg::OpLoad) begin
      if (t.key_index < zph_pkg::TableDepth) begin
        key_table[t.key_index] = t.key_value;
        loads++;
      end else begin
        dropped_loads++;
      end
    end else begin
      hashes_due.push_back(position_hash(t));
      hashes++;
    end
  endfunction

  function void check_result(logic [zph_pkg::KeyW-1:0] got);
    logic [zph_pkg::KeyW-1:0] want;
    if (hashes_due.size() == 0) begin
      $error("hash_value: expected no result, actual %h", got);
      errors++;
    end else begin
      want = hashes_due.pop_front();
      checked++;
      if (got !== want) begin
        $error("hash_value: expected %h, actual %h", want, got);
        errors++;
      end
    end
  endfunction
endclass

module testbench;

  // piece types in board order
  localparam int unsigned TypeKing   = 0;
  localparam int unsigned TypeQueen  = 1;
  localparam int unsigned TypeRook   = 2;
  localparam int unsigned TypeBishop = 3;
  localparam int unsigned TypeKnight = 4;
  localparam int unsigned TypePawn   = 5;

  // castle right bits follow side to move and en passant in the flag word
  localparam int unsigned CastleWk = 2;
  localparam int unsigned CastleBk = 3;
  localparam int unsigned CastleWq = 4;
  localparam int unsigned CastleBq = 5;

  localparam int unsigned FlagW = zph_pkg::FlagW;
  localparam int unsigned KeyW  = zph_pkg::KeyW;
  localparam int unsigned SqW   = zph_pkg::SqW;

  localparam logic [FlagW-1:0] FlagsNone    = '0;
  localparam logic [FlagW-1:0] FlagsBlack   = FlagW'(1) << zph_pkg::FlagBlackToMove;
  localparam logic [FlagW-1:0] FlagsEp      = FlagW'(1) << zph_pkg::FlagEpValid;
  localparam logic [FlagW-1:0] FlagsWk      = FlagW'(1) << CastleWk;
  localparam logic [FlagW-1:0] FlagsBk      = FlagW'(1) << CastleBk;
  localparam logic [FlagW-1:0] FlagsWq      = FlagW'(1) << CastleWq;
  localparam logic [FlagW-1:0] FlagsBq      = FlagW'(1) << CastleBq;
  localparam logic [FlagW-1:0] FlagsCastles = FlagsWk | FlagsBk | FlagsWq | FlagsBq;
  localparam logic [FlagW-1:0] FlagsAll     = '1;

  localparam int unsigned IndexTop    = 2 ** zph_pkg::IdxW - 1;
  localparam int unsigned IdleLimit   = 3000;  // cycles with no transaction on either side
  localparam int unsigned DrainCycles = 80;    // one full hash walk plus margin
  localparam int unsigned RandomItems = 1000;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            push = 1'b0;
  logic            pop = 1'b0;
  logic            full;
  logic            empty;
  logic [KeyW-1:0] hash_value;
  txn_t            drive = '0;

  hash_scoreboard sb = new();

  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned pop_mode = 0;
  int unsigned mode_left = 0;
  int unsigned cycle_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  chess_position_zobrist_hash u_top (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .op            (drive.op),
    .key_index     (drive.key_index),
    .key_value     (drive.key_value),
    .king_board    (drive.boards[TypeKing]),
    .queen_board   (drive.boards[TypeQueen]),
    .rook_board    (drive.boards[TypeRook]),
    .bishop_board  (drive.boards[TypeBishop]),
    .knight_board  (drive.boards[TypeKnight]),
    .pawn_board    (drive.boards[TypePawn]),
    .white_board   (drive.white),
    .position_flags(drive.flags),
    .ep_square     (drive.ep),
    .empty         (empty),
    .pop           (pop),
    .hash_value    (hash_value)
  );

  // Monitor both queue sides at the clock edge. All stimulus changes through
  // nonblocking assignments, so the values read here are the ones the block
  // saw at this edge. The watchdog counts edges with no transaction at all.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        sb.note_input(drive);
      end
      if (pop && !empty) begin
        sb.check_result(hash_value);
      end
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == IdleLimit) begin
        $display("watchdog: no transaction for %0d cycles", IdleLimit);
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: switch among free flow, coin-flip pops, mostly-stalled and a
  // fixed 3-of-7 pattern, each held for a random stretch of cycles.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (mode_left == 0) begin
        pop_mode  <= $urandom_range(0, 3);
        mode_left <= $urandom_range(8, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (pop_mode)
        0: begin
          pop <= 1'b1;
        end
        1: begin
          pop <= ($urandom_range(0, 1) == 1);
        end
        2: begin
          pop <= ($urandom_range(0, 7) == 0);
        end
        default: begin
          pop <= ((cycle_count % 7) < 3);
        end
      endcase
    end
  end

  function automatic logic [KeyW-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly random keys, with the all-zero and all-one corners now and then.
  function automatic logic [KeyW-1:0] key_pick();
    int unsigned roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) begin
      return '0;
    end else if (roll == 1) begin
      return '1;
    end
    return rand64();
  endfunction

  // Random content in every field; callers then set what matters. Fields
  // that the operation ignores thus carry garbage.
  function automatic txn_t noise();
    txn_t t;
    int   ty;
    t.op        = 1'($urandom_range(0, 1));
    t.key_index = zph_pkg::IdxW'($urandom_range(0, IndexTop));
    t.key_value = rand64();
    for (ty = 0; ty < zph_pkg::PieceTypes; ty++) begin
      t.boards[ty] = rand64();
    end
    t.white = rand64();
    t.flags = FlagW'($urandom_range(0, 2 ** FlagW - 1));
    t.ep    = SqW'($urandom_range(0, 2 ** SqW - 1));
    return t;
  endfunction

  function automatic txn_t load_txn(int unsigned idx, logic [KeyW-1:0] key);
    txn_t t;
    t           = noise();
    t.op        = zph_pkg::OpLoad;
    t.key_index = zph_pkg::IdxW'(idx);
    t.key_value = key;
    return t;
  endfunction

  function automatic txn_t position(logic [KeyW-1:0] king, logic [KeyW-1:0] queen,
                                    logic [KeyW-1:0] rook, logic [KeyW-1:0] bishop,
                                    logic [KeyW-1:0] knight, logic [KeyW-1:0] pawn,
                                    logic [KeyW-1:0] white, logic [FlagW-1:0] flags,
                                    logic [SqW-1:0] ep);
    txn_t t;
    t                    = noise();
    t.op                 = zph_pkg::OpHash;
    t.boards[TypeKing]   = king;
    t.boards[TypeQueen]  = queen;
    t.boards[TypeRook]   = rook;
    t.boards[TypeBishop] = bishop;
    t.boards[TypeKnight] = knight;
    t.boards[TypePawn]   = pawn;
    t.white              = white;
    t.flags              = flags;
    t.ep                 = ep;
    return t;
  endfunction

  // Game-like position: up to 32 pieces on distinct squares, random types;
  // colors, flags and en passant square stay random.
  function automatic txn_t game_position();
    txn_t            t;
    logic [KeyW-1:0] occupied;
    int unsigned     sq;
    t        = noise();
    t.op     = zph_pkg::OpHash;
    t.boards = '0;
    occupied = '0;
    repeat ($urandom_range(2, 32)) begin
      sq = $urandom_range(0, zph_pkg::Squares - 1);
      if (!occupied[sq]) begin
        occupied[sq] = 1'b1;
        t.boards[$urandom_range(0, zph_pkg::PieceTypes - 1)][sq] = 1'b1;
      end
    end
    return t;
  endfunction

  // Sparse boards with random overlaps between piece types.
  function automatic txn_t sparse_position();
    txn_t t;
    int   ty;
    t    = noise();
    t.op = zph_pkg::OpHash;
    for (ty = 0; ty < zph_pkg::PieceTypes; ty++) begin
      t.boards[ty] = rand64() & rand64() & rand64();
    end
    return t;
  endfunction

  // Present one transaction and hold it until the block takes it. The sender
  // runs in bursts; between bursts push drops for a random gap. push is only
  // lowered when a gap actually follows, so back-to-back transactions keep it
  // high without a second assignment in the same step.
  task automatic send_txn(input txn_t t);
    int unsigned gap;
    drive <= t;
    push  <= 1'b1;
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) :
                                                 $urandom_range(0, 10);
    end
  endtask

  initial begin
    int unsigned idx;
    int unsigned roll;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Fill every slot first so that no hash ever reads an unwritten key.
    for (idx = 0; idx < zph_pkg::TableDepth; idx++) begin
      send_txn(load_txn(idx, key_pick()));
    end

    // Empty board: only flag keys contribute.
    send_txn(position('0, '0, '0, '0, '0, '0, rand64(), FlagsNone, 6'd0));
    send_txn(position('0, '0, '0, '0, '0, '0, rand64(), FlagsBlack, 6'd0));
    // En passant: corner squares and ordinary target squares.
    send_txn(position('0, '0, '0, '0, '0, '0, rand64(), FlagsEp, 6'd0));
    send_txn(position('0, '0, '0, '0, '0, '0, rand64(), FlagsEp, 6'd63));
    send_txn(position('0, '0, '0, '0, '0, '0, rand64(), FlagsEp, 6'd20));
    send_txn(position('0, '0, '0, '0, '0, '0, rand64(), FlagsEp | FlagsBlack, 6'd43));
    // Each castle right on its own.
    send_txn(position('0, '0, '0, '0, '0, '0, rand64(), FlagsWk, 6'd7));
    send_txn(position('0, '0, '0, '0, '0, '0, rand64(), FlagsBk, 6'd56));
    send_txn(position('0, '0, '0, '0, '0, '0, rand64(), FlagsWq, 6'd9));
    send_txn(position('0, '0, '0, '0, '0, '0, rand64(), FlagsBq, 6'd54));

    // Opening position, white to move, all castle rights.
    send_txn(position(64'h1000_0000_0000_0010, 64'h0800_0000_0000_0008,
                      64'h8100_0000_0000_0081, 64'h2400_0000_0000_0024,
                      64'h4200_0000_0000_0042, 64'h00FF_0000_0000_FF00,
                      64'h0000_0000_0000_FFFF, FlagsCastles, 6'd0));

    // Every square in every board, all white then all black.
    send_txn(position('1, '1, '1, '1, '1, '1, '1, FlagsAll, 6'd63));
    send_txn(position('1, '1, '1, '1, '1, '1, '0, FlagsNone, 6'd0));

    // Reload the corner slots with the extreme keys; two loads past the
    // table end must be dropped without touching any slot.
    send_txn(load_txn(0, '0));
    send_txn(load_txn(zph_pkg::Squares * zph_pkg::PieceKinds - 1, '1));
    send_txn(load_txn(zph_pkg::TableDepth - 1, '1));
    send_txn(load_txn(zph_pkg::TableDepth, rand64()));
    send_txn(load_txn(IndexTop, rand64()));

    // Overlapping boards on the corner squares: reads slot 0, the last piece
    // slot and every extra key.
    send_txn(position(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001,
                      64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001,
                      64'h8000_0000_0000_0001, 64'h8000_0000_0000_0001,
                      64'h0000_0000_0000_0001, FlagsAll, 6'd45));
    send_txn(position('1, '1, '1, '1, '1, '1, rand64(), FlagsAll, 6'd27));

    // Random mix: key reloads, dropped loads and three kinds of position.
    repeat (RandomItems) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        send_txn(load_txn($urandom_range(0, zph_pkg::TableDepth - 1), key_pick()));
      end else if (roll < 48) begin
        send_txn(load_txn($urandom_range(zph_pkg::TableDepth, IndexTop), rand64()));
      end else if (roll < 75) begin
        send_txn(game_position());
      end else if (roll < 90) begin
        send_txn(position(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                          rand64(), FlagW'($urandom_range(0, 2 ** FlagW - 1)),
                          SqW'($urandom_range(0, 2 ** SqW - 1))));
      end else begin
        send_txn(sparse_position());
      end
    end
    push <= 1'b0;

    // Drain: wait for every pending hash, then hold long enough for a stray
    // extra result to show up.
    while (sb.hashes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    $display("covered: %0d key writes, %0d loads past the table end dropped",
             sb.loads, sb.dropped_loads);
    $display("covered: %0d positions hashed, %0d hash results checked, %0d mismatches",
             sb.hashes, sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
